>>> rtl/core/pea_pkg.sv
// Package for the proportional energy apportioner: widths, codes, FSM types
// and the request/response structs of the shared multiply-divide unit.
// No dependencies.
package pea_pkg;

  localparam int MAX_UNITS = 16;
  localparam int IDX_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W     = $clog2(MAX_UNITS + 1);

  localparam int CMD_W     = 3;
  localparam int UIDX_W    = 4;
  localparam int CAP_W     = 16;
  localparam int RT_W      = 24;
  localparam int PIN_W     = 21;
  localparam int PWR_W     = 20;
  localparam int OE_W      = 32;
  localparam int TIME_W    = 32;
  localparam int EN_W      = 48;
  localparam int FRAC_W    = 16;
  localparam int ACT_W     = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SUM_W  = RT_W + CNT_W;
  localparam int ESUM_W = EN_W + CNT_W;
  localparam int V_W    = ESUM_W + 2;

  localparam logic [EN_W-1:0] E48MAX = {EN_W{1'b1}};

  // shared multiply-divide unit: q = floor(a * b / c)
  localparam int MDU_A_W   = 48;
  localparam int MDU_B_W   = 32;
  localparam int MDU_C_W   = 32;
  localparam int MDU_P_W   = MDU_A_W + MDU_B_W;
  localparam int MDU_CNT_W = $clog2(MDU_P_W);

  // Wh*2^16 per W*ms after the 2^16 pre-shift: 2 * 3600 * 1000
  localparam logic [MDU_C_W-1:0] TRAP_DIVISOR = 32'd7200000;

  typedef enum logic [CMD_W-1:0] {
    CMD_UNIT_REPORT    = 3'd0,
    CMD_OUTDOOR_POWER  = 3'd1,
    CMD_OUTDOOR_ENERGY = 3'd2,
    CMD_RECALC_POWER   = 3'd3,
    CMD_APPLY_ENERGY   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_UNITS  = 3'd0,
    CFG_INVALID_CAP   = 3'd1,
    CFG_INVALID_RT    = 3'd2,
    CFG_MIN_INTERVAL  = 3'd3,
    CFG_MAX_INTERVAL  = 3'd4,
    CFG_SEED_GRACE    = 3'd5
  } cfg_e;

  typedef enum logic [1:0] {
    MODE_POWER,
    MODE_SEED,
    MODE_SPREAD
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SEED,
    ACT_SPREAD
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KNOWN,
    ST_DECIDE,
    ST_SUM,
    ST_EQ,
    ST_EQ_WAIT,
    ST_SHARE,
    ST_SHARE_WAIT,
    ST_UNIT,
    ST_INT_WAIT,
    ST_DRIFT,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MDU_IDLE,
    MDU_MUL,
    MDU_DIV
  } mdu_phase_e;

  typedef struct packed {
    logic               start;
    logic [MDU_A_W-1:0] a;
    logic [MDU_B_W-1:0] b;
    logic [MDU_C_W-1:0] c;
  } mdu_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [EN_W-1:0] q;
  } mdu_rsp_t;

endpackage

>>> rtl/core/pea_if.sv
// Valid/ready channel interfaces of the energy apportioner: input items,
// results and configuration writes. Depends on pea_pkg.
interface pea_item_if;
  logic                           valid;
  logic                           ready;
  logic [pea_pkg::CMD_W-1:0]      command;
  logic [pea_pkg::UIDX_W-1:0]     unit_index;
  logic [pea_pkg::CAP_W-1:0]      capacity_request;
  logic                           thermo_active;
  logic                           runtime_present;
  logic [pea_pkg::RT_W-1:0]       runtime_hours;
  logic signed [pea_pkg::PIN_W-1:0] outdoor_power_w;
  logic signed [pea_pkg::OE_W-1:0]  outdoor_energy_wh;
  logic [pea_pkg::TIME_W-1:0]     time_ms;

  modport source (output valid, command, unit_index, capacity_request, thermo_active,
                  runtime_present, runtime_hours, outdoor_power_w, outdoor_energy_wh,
                  time_ms, input ready);
  modport sink (input valid, command, unit_index, capacity_request, thermo_active,
                runtime_present, runtime_hours, outdoor_power_w, outdoor_energy_wh,
                time_ms, output ready);
endinterface

interface pea_result_if;
  logic                        valid;
  logic                        ready;
  logic [pea_pkg::UIDX_W-1:0]  result_unit;
  logic [pea_pkg::PWR_W-1:0]   estimated_power_w;
  logic [pea_pkg::EN_W-1:0]    accumulated_energy;
  logic                        energy_changed;
  logic                        applied;
  logic                        last_unit;

  modport source (output valid, result_unit, estimated_power_w, accumulated_energy,
                  energy_changed, applied, last_unit, input ready);
  modport sink (input valid, result_unit, estimated_power_w, accumulated_energy,
                energy_changed, applied, last_unit, output ready);
endinterface

interface pea_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pea_pkg::CFG_IDX_W-1:0]   index;
  logic [pea_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pea_mdu.sv
// Shared iterative multiply-divide unit: q = floor(a * b / c).
// Shift-add multiply, one bit a cycle, then restoring divide. Uses pea_pkg.
module pea_mdu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pea_pkg::mdu_req_t req_i,
  output pea_pkg::mdu_rsp_t rsp_o
);

  pea_pkg::mdu_phase_e phase_q, phase_d;
  logic [pea_pkg::MDU_CNT_W-1:0] cnt_q;
  logic [pea_pkg::MDU_A_W-1:0]   a_q;
  logic [pea_pkg::MDU_C_W-1:0]   c_q;
  logic [pea_pkg::MDU_P_W-1:0]   p_q;
  logic [pea_pkg::MDU_C_W-1:0]   r_q;
  logic                          done_q;

  logic                          mul_last, div_last;
  logic [pea_pkg::MDU_A_W:0]     mul_sum;
  logic [pea_pkg::MDU_C_W:0]     trial;
  logic                          ge;

  always_comb begin
    mul_last = (cnt_q == pea_pkg::MDU_CNT_W'(pea_pkg::MDU_B_W - 1));
    div_last = (cnt_q == pea_pkg::MDU_CNT_W'(pea_pkg::MDU_P_W - 1));
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      pea_pkg::MDU_IDLE: if (req_i.start) phase_d = pea_pkg::MDU_MUL;
      pea_pkg::MDU_MUL:  if (mul_last) phase_d = pea_pkg::MDU_DIV;
      pea_pkg::MDU_DIV:  if (div_last) phase_d = pea_pkg::MDU_IDLE;
      default:           phase_d = pea_pkg::MDU_IDLE;
    endcase
  end

  // step arithmetic
  always_comb begin
    mul_sum = {1'b0, p_q[pea_pkg::MDU_P_W-1:pea_pkg::MDU_B_W]}
            + (p_q[0] ? {1'b0, a_q} : '0);
    trial   = {r_q, p_q[pea_pkg::MDU_P_W-1]};
    ge      = (trial >= {1'b0, c_q});
  end

  always_comb begin
    rsp_o.busy = (phase_q != pea_pkg::MDU_IDLE);
    rsp_o.done = done_q;
    rsp_o.q    = p_q[pea_pkg::EN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pea_pkg::MDU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      a_q     <= '0;
      c_q     <= '0;
      p_q     <= '0;
      r_q     <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == pea_pkg::MDU_DIV) && div_last;
      unique case (phase_q)
        pea_pkg::MDU_IDLE: begin
          if (req_i.start) begin
            a_q   <= req_i.a;
            c_q   <= req_i.c;
            p_q   <= {{pea_pkg::MDU_A_W{1'b0}}, req_i.b};
            r_q   <= '0;
            cnt_q <= '0;
          end
        end
        pea_pkg::MDU_MUL: begin
          p_q   <= {mul_sum, p_q[pea_pkg::MDU_B_W-1:1]};
          cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
        end
        pea_pkg::MDU_DIV: begin
          r_q   <= ge ? pea_pkg::MDU_C_W'(trial - {1'b0, c_q})
                      : trial[pea_pkg::MDU_C_W-1:0];
          p_q   <= {p_q[pea_pkg::MDU_P_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/proportional_energy_apportioner_unit.sv
// Proportional energy apportioner, top level: unit table, sequencer, result
// register. Uses pea_pkg, the channel interfaces in pea_if and pea_mdu.
//
// The block keeps up to MAX_UNITS indoor units and splits the outdoor power
// or metered energy among them by capacity (or, when seeding, runtime)
// weight; energy is Wh with 16 fraction bits, saturating at 2^48-1.
// Unit reports, outdoor power and outdoor energy transfers give no result.
// Recalculate power and apply energy walk the n active units under a small
// sequencer: a weight-sum pass over the units (after a runtime check pass
// on apply energy), then per unit one share step, with every proportional
// share but the last weighted unit's remainder, the equal share and every
// trapezoid increment computed by the single shared multiply-divide unit
// (32 multiply steps, 80 divide steps). Then n results leave through the
// output register, one per cycle while the sink is ready. The input is not
// ready until the last result has been loaded; the last one may still wait
// in the output register while the next transfer is taken. Configuration
// writes are always ready and must only be made while the block is idle.
module proportional_energy_apportioner_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  pea_item_if.sink      item_i,
  pea_result_if.source  result_o,
  pea_cfg_if.sink       cfg_i
);

  // configuration
  logic [pea_pkg::ACT_W-1:0]  cfg_active_q;
  logic [pea_pkg::CAP_W-1:0]  cfg_inv_cap_q;
  logic [pea_pkg::RT_W-1:0]   cfg_inv_rt_q;
  logic [31:0]                cfg_min_q, cfg_max_q, cfg_grace_q;

  // unit table
  logic [pea_pkg::CAP_W-1:0] cap_q   [pea_pkg::MAX_UNITS];
  logic                      thermo_q[pea_pkg::MAX_UNITS];
  logic                      rtv_q   [pea_pkg::MAX_UNITS];
  logic [pea_pkg::RT_W-1:0]  rt_q    [pea_pkg::MAX_UNITS];
  logic [pea_pkg::PWR_W-1:0] pwr_q   [pea_pkg::MAX_UNITS];
  logic [pea_pkg::PWR_W-1:0] anc_q   [pea_pkg::MAX_UNITS];
  logic [pea_pkg::EN_W-1:0]  en_q    [pea_pkg::MAX_UNITS];

  // outdoor state and flags
  logic [pea_pkg::PWR_W-1:0]  opwr_q;
  logic [pea_pkg::OE_W-1:0]   oe_q, prev_oe_q;
  logic [pea_pkg::TIME_W-1:0] anchor_time_q, first_time_q;
  logic f_power_q, f_meter_q, f_anchor_q, f_first_q, f_seeded_q, f_prov_q;

  // sequencer
  pea_pkg::state_e st_q, st_d;
  pea_pkg::mode_e  mode_q;
  logic [pea_pkg::IDX_W-1:0]  idx_q, nlast_q, last_q;
  logic [pea_pkg::TIME_W-1:0] now_q, dt_q;
  logic                       do_energy_q, advance_q, prov_q, known_q;
  logic                       changed_q, applied_q;
  logic [pea_pkg::SUM_W-1:0]  sum_q;
  logic [pea_pkg::EN_W-1:0]   total_q, given_q, eq_q, share_q;
  logic [pea_pkg::ESUM_W-1:0] esum_q;

  // result register
  logic                       out_valid_q;
  logic [pea_pkg::UIDX_W-1:0] res_unit_q;
  logic [pea_pkg::PWR_W-1:0]  res_pwr_q;
  logic [pea_pkg::EN_W-1:0]   res_en_q;
  logic                       res_changed_q, res_applied_q, res_last_q;

  pea_pkg::mdu_req_t mdu_req;
  pea_pkg::mdu_rsp_t mdu_rsp;

  pea_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  // ---- combinational helpers ----
  logic [pea_pkg::CNT_W-1:0]  n_cnt;
  logic                       in_fire, idx_at_last, unit_done, share_div, out_load;
  logic [pea_pkg::RT_W-1:0]   cap_w, rt_w, cur_w;
  logic                       cur_known;
  logic [pea_pkg::TIME_W-1:0] dt_raw, elapsed;
  logic                       rc_de;
  pea_pkg::action_e           act;
  logic                       act_prov;
  logic [pea_pkg::EN_W-1:0]   addend, en_new;
  logic [pea_pkg::EN_W:0]     en_sum;
  logic [pea_pkg::PWR_W:0]    trap_pwr;
  logic signed [pea_pkg::V_W-1:0] drift_v;
  logic [pea_pkg::EN_W-1:0]   drift_en;

  always_comb begin
    // active_units above the table size saturates
    if (32'(cfg_active_q) > pea_pkg::MAX_UNITS) begin
      n_cnt = pea_pkg::CNT_W'(pea_pkg::MAX_UNITS);
    end else begin
      n_cnt = pea_pkg::CNT_W'(cfg_active_q);
    end
    in_fire     = item_i.valid && item_i.ready;
    idx_at_last = (idx_q == nlast_q);

    cap_w = (thermo_q[idx_q] && (cap_q[idx_q] != '0) && (cap_q[idx_q] < cfg_inv_cap_q))
          ? pea_pkg::RT_W'(cap_q[idx_q]) : '0;
    rt_w  = (!prov_q && (rt_q[idx_q] != '0)) ? rt_q[idx_q] : '0;
    cur_w = (mode_q == pea_pkg::MODE_SEED) ? rt_w : cap_w;
    cur_known = rtv_q[idx_q] && (rt_q[idx_q] < cfg_inv_rt_q);

    // wrap-safe interval since the integration anchor
    dt_raw = item_i.time_ms - anchor_time_q;
    rc_de  = !f_meter_q && f_anchor_q && (dt_raw >= cfg_min_q);

    // apply-energy decision
    elapsed  = now_q - first_time_q;
    act      = pea_pkg::ACT_NONE;
    act_prov = 1'b0;
    if (!f_seeded_q) begin
      if (known_q || (elapsed >= cfg_grace_q)) begin
        act      = pea_pkg::ACT_SEED;
        act_prov = !known_q;
      end
    end else if (f_prov_q && known_q) begin
      act = pea_pkg::ACT_SEED;
    end else if (oe_q < prev_oe_q) begin
      act      = pea_pkg::ACT_SEED;
      act_prov = f_prov_q;
    end else if (oe_q != prev_oe_q) begin
      act = pea_pkg::ACT_SPREAD;
    end

    share_div = (sum_q != '0) && (cur_w != '0) && (idx_q != last_q);
    unit_done = ((st_q == pea_pkg::ST_UNIT)
                 && !((mode_q == pea_pkg::MODE_POWER) && do_energy_q))
             || ((st_q == pea_pkg::ST_INT_WAIT) && mdu_rsp.done);
    out_load  = (st_q == pea_pkg::ST_EMIT) && (!out_valid_q || result_o.ready);

    // seed: load share; else saturating add (power: trapezoid increment)
    addend = (mode_q == pea_pkg::MODE_POWER) ? mdu_rsp.q : share_q;
    en_sum = {1'b0, en_q[idx_q]} + {1'b0, addend};
    if (mode_q == pea_pkg::MODE_SEED) begin
      en_new = share_q;
    end else if (en_sum[pea_pkg::EN_W]) begin
      en_new = pea_pkg::E48MAX;
    end else begin
      en_new = en_sum[pea_pkg::EN_W-1:0];
    end

    trap_pwr = {1'b0, anc_q[idx_q]} + {1'b0, share_q[pea_pkg::PWR_W-1:0]};

    // drift fix on the last unit, clamped to the 48-bit range
    drift_v = $signed(pea_pkg::V_W'(en_q[idx_q]))
            + $signed(pea_pkg::V_W'({oe_q, {pea_pkg::FRAC_W{1'b0}}}))
            - $signed(pea_pkg::V_W'(esum_q));
    if (drift_v[pea_pkg::V_W-1]) begin
      drift_en = '0;
    end else if (drift_v > $signed(pea_pkg::V_W'(pea_pkg::E48MAX))) begin
      drift_en = pea_pkg::E48MAX;
    end else begin
      drift_en = drift_v[pea_pkg::EN_W-1:0];
    end
  end

  // ---- next state ----
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pea_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (pea_pkg::cmd_e'(item_i.command))
            pea_pkg::CMD_RECALC_POWER:
              if ((n_cnt != '0) && f_power_q) st_d = pea_pkg::ST_SUM;
            pea_pkg::CMD_APPLY_ENERGY:
              if ((n_cnt != '0) && f_meter_q) st_d = pea_pkg::ST_KNOWN;
            default: ;
          endcase
        end
      end
      pea_pkg::ST_KNOWN:  if (idx_at_last) st_d = pea_pkg::ST_DECIDE;
      pea_pkg::ST_DECIDE: begin
        st_d = (act == pea_pkg::ACT_NONE) ? pea_pkg::ST_EMIT : pea_pkg::ST_SUM;
      end
      pea_pkg::ST_SUM:    if (idx_at_last) st_d = pea_pkg::ST_EQ;
      pea_pkg::ST_EQ: begin
        st_d = (sum_q == '0) ? pea_pkg::ST_EQ_WAIT : pea_pkg::ST_SHARE;
      end
      pea_pkg::ST_EQ_WAIT: if (mdu_rsp.done) st_d = pea_pkg::ST_SHARE;
      pea_pkg::ST_SHARE: begin
        st_d = share_div ? pea_pkg::ST_SHARE_WAIT : pea_pkg::ST_UNIT;
      end
      pea_pkg::ST_SHARE_WAIT: if (mdu_rsp.done) st_d = pea_pkg::ST_UNIT;
      pea_pkg::ST_UNIT, pea_pkg::ST_INT_WAIT: begin
        if ((st_q == pea_pkg::ST_UNIT) && (mode_q == pea_pkg::MODE_POWER) && do_energy_q) begin
          st_d = pea_pkg::ST_INT_WAIT;
        end
        if (unit_done) begin
          if (!idx_at_last) begin
            st_d = pea_pkg::ST_SHARE;
          end else if (mode_q == pea_pkg::MODE_SPREAD) begin
            st_d = pea_pkg::ST_DRIFT;
          end else begin
            st_d = pea_pkg::ST_FINISH;
          end
        end
      end
      pea_pkg::ST_DRIFT:  st_d = pea_pkg::ST_FINISH;
      pea_pkg::ST_FINISH: st_d = pea_pkg::ST_EMIT;
      pea_pkg::ST_EMIT:   if (out_load && idx_at_last) st_d = pea_pkg::ST_IDLE;
      default:            st_d = pea_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer outputs: shared unit requests ----
  always_comb begin
    mdu_req = '0;
    unique case (st_q)
      pea_pkg::ST_EQ: begin
        if (sum_q == '0) begin
          mdu_req.start = 1'b1;
          mdu_req.a     = total_q;
          mdu_req.b     = pea_pkg::MDU_B_W'(1);
          mdu_req.c     = pea_pkg::MDU_C_W'(n_cnt);
        end
      end
      pea_pkg::ST_SHARE: begin
        if (share_div) begin
          mdu_req.start = 1'b1;
          mdu_req.a     = total_q;
          mdu_req.b     = pea_pkg::MDU_B_W'(cur_w);
          mdu_req.c     = pea_pkg::MDU_C_W'(sum_q);
        end
      end
      pea_pkg::ST_UNIT: begin
        if ((mode_q == pea_pkg::MODE_POWER) && do_energy_q) begin
          mdu_req.start = 1'b1;
          mdu_req.a     = pea_pkg::MDU_A_W'({trap_pwr, {pea_pkg::FRAC_W{1'b0}}});
          mdu_req.b     = dt_q;
          mdu_req.c     = pea_pkg::TRAP_DIVISOR;
        end
      end
      default: ;
    endcase
  end

  assign item_i.ready = (st_q == pea_pkg::ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid              = out_valid_q;
  assign result_o.result_unit        = res_unit_q;
  assign result_o.estimated_power_w  = res_pwr_q;
  assign result_o.accumulated_energy = res_en_q;
  assign result_o.energy_changed     = res_changed_q;
  assign result_o.applied            = res_applied_q;
  assign result_o.last_unit          = res_last_q;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_active_q  <= pea_pkg::ACT_W'(1);
      cfg_inv_cap_q <= '1;
      cfg_inv_rt_q  <= '1;
      cfg_min_q     <= 32'd1000;
      cfg_max_q     <= 32'd600000;
      cfg_grace_q   <= 32'd300000;
    end else if (cfg_i.valid) begin
      case (pea_pkg::cfg_e'(cfg_i.index))
        pea_pkg::CFG_ACTIVE_UNITS: cfg_active_q  <= cfg_i.data[pea_pkg::ACT_W-1:0];
        pea_pkg::CFG_INVALID_CAP:  cfg_inv_cap_q <= cfg_i.data[pea_pkg::CAP_W-1:0];
        pea_pkg::CFG_INVALID_RT:   cfg_inv_rt_q  <= cfg_i.data[pea_pkg::RT_W-1:0];
        pea_pkg::CFG_MIN_INTERVAL: cfg_min_q     <= cfg_i.data;
        pea_pkg::CFG_MAX_INTERVAL: cfg_max_q     <= cfg_i.data;
        pea_pkg::CFG_SEED_GRACE:   cfg_grace_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---- unit table ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pea_pkg::MAX_UNITS; i++) begin
        cap_q[i]    <= '0;
        thermo_q[i] <= 1'b0;
        rtv_q[i]    <= 1'b0;
        rt_q[i]     <= '0;
        pwr_q[i]    <= '0;
        anc_q[i]    <= '0;
        en_q[i]     <= '0;
      end
    end else begin
      // unit report
      if (in_fire && (pea_pkg::cmd_e'(item_i.command) == pea_pkg::CMD_UNIT_REPORT)
          && (32'(item_i.unit_index) < pea_pkg::MAX_UNITS)) begin
        cap_q[pea_pkg::IDX_W'(item_i.unit_index)]    <= item_i.capacity_request;
        thermo_q[pea_pkg::IDX_W'(item_i.unit_index)] <= item_i.thermo_active;
        rtv_q[pea_pkg::IDX_W'(item_i.unit_index)]    <= item_i.runtime_present;
        rt_q[pea_pkg::IDX_W'(item_i.unit_index)]     <= item_i.runtime_hours;
      end
      if (unit_done) begin
        if (mode_q == pea_pkg::MODE_POWER) begin
          pwr_q[idx_q] <= share_q[pea_pkg::PWR_W-1:0];
          if (advance_q) anc_q[idx_q] <= share_q[pea_pkg::PWR_W-1:0];
          if (st_q == pea_pkg::ST_INT_WAIT) en_q[idx_q] <= en_new;
        end else begin
          en_q[idx_q] <= en_new;
        end
      end
      if (st_q == pea_pkg::ST_DRIFT) en_q[idx_q] <= drift_en;
    end
  end

  // ---- sequencer datapath and outdoor state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= pea_pkg::ST_IDLE;
      mode_q        <= pea_pkg::MODE_POWER;
      opwr_q        <= '0;
      oe_q          <= '0;
      prev_oe_q     <= '0;
      anchor_time_q <= '0;
      first_time_q  <= '0;
      f_power_q     <= 1'b0;
      f_meter_q     <= 1'b0;
      f_anchor_q    <= 1'b0;
      f_first_q     <= 1'b0;
      f_seeded_q    <= 1'b0;
      f_prov_q      <= 1'b0;
      idx_q         <= '0;
      nlast_q       <= '0;
      last_q        <= '0;
      now_q         <= '0;
      dt_q          <= '0;
      do_energy_q   <= 1'b0;
      advance_q     <= 1'b0;
      prov_q        <= 1'b0;
      known_q       <= 1'b0;
      changed_q     <= 1'b0;
      applied_q     <= 1'b0;
      sum_q         <= '0;
      total_q       <= '0;
      given_q       <= '0;
      eq_q          <= '0;
      share_q       <= '0;
      esum_q        <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        pea_pkg::ST_IDLE: begin
          if (in_fire) begin
            now_q   <= item_i.time_ms;
            nlast_q <= pea_pkg::IDX_W'(n_cnt - 1'b1);
            idx_q   <= '0;
            sum_q   <= '0;
            last_q  <= '0;
            given_q <= '0;
            case (pea_pkg::cmd_e'(item_i.command))
              pea_pkg::CMD_OUTDOOR_POWER: begin
                // negative readings count as zero
                opwr_q    <= item_i.outdoor_power_w[pea_pkg::PIN_W-1]
                           ? '0 : item_i.outdoor_power_w[pea_pkg::PWR_W-1:0];
                f_power_q <= 1'b1;
              end
              pea_pkg::CMD_OUTDOOR_ENERGY: begin
                oe_q      <= item_i.outdoor_energy_wh[pea_pkg::OE_W-1]
                           ? '0 : item_i.outdoor_energy_wh;
                f_meter_q <= 1'b1;
              end
              pea_pkg::CMD_RECALC_POWER: begin
                mode_q      <= pea_pkg::MODE_POWER;
                prov_q      <= 1'b0;
                total_q     <= pea_pkg::EN_W'(opwr_q);
                do_energy_q <= rc_de;
                advance_q   <= f_meter_q || !f_anchor_q || rc_de;
                dt_q        <= (dt_raw > cfg_max_q) ? cfg_max_q : dt_raw;
                changed_q   <= rc_de;
                applied_q   <= 1'b0;
              end
              pea_pkg::CMD_APPLY_ENERGY: begin
                if ((n_cnt != '0) && f_meter_q && !f_first_q) begin
                  first_time_q <= item_i.time_ms;
                  f_first_q    <= 1'b1;
                end
                known_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        pea_pkg::ST_KNOWN: begin
          known_q <= known_q && cur_known;
          idx_q   <= idx_at_last ? '0 : idx_q + 1'b1;
        end
        pea_pkg::ST_DECIDE: begin
          applied_q <= (act != pea_pkg::ACT_NONE);
          changed_q <= (act != pea_pkg::ACT_NONE);
          prov_q    <= act_prov;
          esum_q    <= '0;
          if (act == pea_pkg::ACT_SPREAD) begin
            mode_q  <= pea_pkg::MODE_SPREAD;
            total_q <= pea_pkg::EN_W'({oe_q - prev_oe_q, {pea_pkg::FRAC_W{1'b0}}});
          end else begin
            mode_q  <= pea_pkg::MODE_SEED;
            total_q <= pea_pkg::EN_W'({oe_q, {pea_pkg::FRAC_W{1'b0}}});
          end
        end
        pea_pkg::ST_SUM: begin
          sum_q <= sum_q + pea_pkg::SUM_W'(cur_w);
          if (cur_w != '0) last_q <= idx_q;
          idx_q <= idx_at_last ? '0 : idx_q + 1'b1;
        end
        pea_pkg::ST_EQ_WAIT: begin
          if (mdu_rsp.done) eq_q <= mdu_rsp.q;
        end
        pea_pkg::ST_SHARE: begin
          if (sum_q == '0) begin
            share_q <= eq_q;
          end else if (cur_w == '0) begin
            share_q <= '0;
          end else if (idx_q == last_q) begin
            // last weighted unit takes the remainder
            share_q <= total_q - given_q;
          end
        end
        pea_pkg::ST_SHARE_WAIT: begin
          if (mdu_rsp.done) begin
            share_q <= mdu_rsp.q;
            given_q <= given_q + mdu_rsp.q;
          end
        end
        pea_pkg::ST_UNIT, pea_pkg::ST_INT_WAIT: begin
          if (unit_done) begin
            if (mode_q == pea_pkg::MODE_SPREAD) begin
              esum_q <= esum_q + pea_pkg::ESUM_W'(en_new);
            end
            if (!idx_at_last) idx_q <= idx_q + 1'b1;
          end
        end
        pea_pkg::ST_FINISH: begin
          idx_q <= '0;
          if (mode_q == pea_pkg::MODE_POWER) begin
            if (advance_q) begin
              anchor_time_q <= now_q;
              f_anchor_q    <= 1'b1;
            end
          end else begin
            prev_oe_q <= oe_q;
            if (mode_q == pea_pkg::MODE_SEED) begin
              f_seeded_q <= 1'b1;
              f_prov_q   <= prov_q;
              f_anchor_q <= 1'b0;
            end
          end
        end
        pea_pkg::ST_EMIT: begin
          if (out_load) idx_q <= idx_at_last ? '0 : idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      res_unit_q    <= '0;
      res_pwr_q     <= '0;
      res_en_q      <= '0;
      res_changed_q <= 1'b0;
      res_applied_q <= 1'b0;
      res_last_q    <= 1'b0;
    end else if (out_load) begin
      out_valid_q   <= 1'b1;
      res_unit_q    <= pea_pkg::UIDX_W'(idx_q);
      res_pwr_q     <= pwr_q[idx_q];
      res_en_q      <= en_q[idx_q];
      res_changed_q <= changed_q;
      res_applied_q <= applied_q;
      res_last_q    <= idx_at_last;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> tb/proportional_energy_apportioner_unit_tb.sv
// Self-checking testbench for proportional_energy_apportioner_unit: random bursty
// stimulus, a cycle-free predictor of the unit table and an in-order result check.
// Depends on pea_pkg, the channel interfaces in pea_if and the block's RTL.
module proportional_energy_apportioner_unit_tb;
  import pea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam int SETTLE_CYCLES = 4500;

  typedef struct {
    logic [2:0]         cmd;
    logic [3:0]         idx;
    logic [15:0]        cap;
    logic               thermo;
    logic               rt_present;
    logic [23:0]        rt;
    logic signed [20:0] pwr;
    logic signed [31:0] nrg;
    logic [31:0]        tm;
  } report_t;

  typedef struct {
    logic [3:0]  unit;
    logic [19:0] pwr;
    logic [47:0] nrg;
    logic        changed;
    logic        applied;
    logic        last;
  } share_t;

  logic clk_i;
  logic rst_ni;

  pea_item_if   item ();
  pea_result_if res ();
  pea_cfg_if    cfg ();

  proportional_energy_apportioner_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item),
    .result_o(res),
    .cfg_i   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the unit table and registers
  // ---------------------------------------------------------------------------
  logic [4:0]  m_active;
  logic [15:0] m_inv_cap;
  logic [23:0] m_inv_rt;
  logic [31:0] m_min_iv, m_max_iv, m_grace;

  logic [15:0] u_cap [MAX_UNITS];
  logic        u_thermo [MAX_UNITS];
  logic        u_rt_ok [MAX_UNITS];
  logic [23:0] u_rt [MAX_UNITS];
  logic [19:0] u_pwr [MAX_UNITS];
  logic [19:0] u_anchor_pwr [MAX_UNITS];
  logic [47:0] u_nrg [MAX_UNITS];
  logic [19:0] od_pwr;
  logic [31:0] od_nrg, od_nrg_prev, anchor_ms, first_ms;
  logic        seen_pwr, seen_meter, anchor_ok, first_ok, seeded, provisional;

  // scratch for the proportional split
  logic [127:0] wt [MAX_UNITS];
  logic [127:0] portion [MAX_UNITS];

  report_t pend_q[$];
  share_t  expect_q[$];

  int n_accepted, n_results, n_errors;

  function automatic logic [47:0] sat48(input logic [127:0] v);
    return (v > 128'(E48MAX)) ? E48MAX : v[47:0];
  endfunction

  // floor(total*w/sum) per weighted unit, remainder to last weighted unit,
  // equal split when no unit carries weight
  function automatic void split_total(input logic [127:0] total, input int n);
    logic [127:0] sum, given;
    int last;
    sum = 0; given = 0; last = 0;
    for (int i = 0; i < n; i++) begin
      sum += wt[i];
      if (wt[i] != 0) last = i;
    end
    for (int i = 0; i < n; i++) begin
      if (sum == 0) portion[i] = total / n;
      else if (wt[i] == 0) portion[i] = 0;
      else if (i == last) portion[i] = total - given;
      else begin
        portion[i] = (total * wt[i]) / sum;
        given += portion[i];
      end
    end
  endfunction

  function automatic void load_cap_weights(input int n);
    for (int i = 0; i < n; i++)
      wt[i] = (u_thermo[i] && u_cap[i] != 0 && u_cap[i] < m_inv_cap) ? 128'(u_cap[i]) : 0;
  endfunction

  function automatic void reseed(input int n, input logic prov);
    for (int i = 0; i < n; i++) wt[i] = (!prov && u_rt[i] != 0) ? 128'(u_rt[i]) : 0;
    split_total(128'(od_nrg) << 16, n);
    for (int i = 0; i < n; i++) u_nrg[i] = portion[i][47:0];
    od_nrg_prev = od_nrg;
    seeded      = 1'b1;
    provisional = prov;
    anchor_ok   = 1'b0;
  endfunction

  function automatic void spread_delta(input int n, input logic [31:0] delta);
    logic [127:0] total, target, diff;
    load_cap_weights(n);
    split_total(128'(delta) << 16, n);
    total = 0;
    for (int i = 0; i < n; i++) begin
      u_nrg[i] = sat48(128'(u_nrg[i]) + portion[i]);
      total += u_nrg[i];
    end
    // drift correction lands on the last active unit, clamped to 0..2^48-1
    target = 128'(od_nrg) << 16;
    if (target >= total) u_nrg[n-1] = sat48(128'(u_nrg[n-1]) + (target - total));
    else begin
      diff = total - target;
      u_nrg[n-1] = (128'(u_nrg[n-1]) >= diff) ? u_nrg[n-1] - diff[47:0] : '0;
    end
    od_nrg_prev = od_nrg;
  endfunction

  function automatic logic recalc_power(input int n, input logic [31:0] now);
    logic        integ, do_nrg, advance;
    logic [31:0] dt;
    logic [127:0] a;
    integ  = !seen_meter;
    do_nrg = 1'b0;
    dt     = 0;
    load_cap_weights(n);
    split_total(128'(od_pwr), n);
    if (integ && anchor_ok) begin
      dt = now - anchor_ms;
      if (dt >= m_min_iv) begin
        if (dt > m_max_iv) dt = m_max_iv;
        do_nrg = 1'b1;
      end
    end
    advance = !integ || !anchor_ok || do_nrg;
    for (int i = 0; i < n; i++) begin
      if (do_nrg) begin
        a = (128'(u_anchor_pwr[i]) + portion[i]) * dt;
        u_nrg[i] = sat48(128'(u_nrg[i]) + (a * 65536) / 7200000);
      end
      u_pwr[i] = portion[i][19:0];
      if (advance) u_anchor_pwr[i] = portion[i][19:0];
    end
    if (advance) begin
      anchor_ms = now;
      anchor_ok = 1'b1;
    end
    return do_nrg;
  endfunction

  function automatic logic apply_energy(input int n, input logic [31:0] now);
    logic known;
    known = 1'b1;
    if (!first_ok) begin
      first_ms = now;
      first_ok = 1'b1;
    end
    for (int i = 0; i < n; i++)
      if (!u_rt_ok[i] || u_rt[i] >= m_inv_rt) known = 1'b0;
    if (!seeded) begin
      if (!known && (now - first_ms) < m_grace) return 1'b0;
      reseed(n, !known);
      return 1'b1;
    end
    if (provisional && known) begin
      reseed(n, 1'b0);
      return 1'b1;
    end
    if (od_nrg < od_nrg_prev) begin       // meter went backwards: start over
      reseed(n, provisional);
      return 1'b1;
    end
    if (od_nrg == od_nrg_prev) return 1'b0;
    spread_delta(n, od_nrg - od_nrg_prev);
    return 1'b1;
  endfunction

  // work out the results of one accepted transfer
  function automatic void predict_shares(input report_t it);
    int     n;
    logic   chg, app;
    share_t s;
    n   = (m_active > MAX_UNITS) ? MAX_UNITS : int'(m_active);
    chg = 1'b0;
    app = 1'b0;
    case (it.cmd)
      CMD_UNIT_REPORT: begin
        u_cap[it.idx]    = it.cap;
        u_thermo[it.idx] = it.thermo;
        u_rt_ok[it.idx]  = it.rt_present;
        u_rt[it.idx]     = it.rt;
        return;
      end
      CMD_OUTDOOR_POWER: begin
        od_pwr   = it.pwr[20] ? '0 : it.pwr[19:0];
        seen_pwr = 1'b1;
        return;
      end
      CMD_OUTDOOR_ENERGY: begin
        od_nrg     = it.nrg[31] ? '0 : it.nrg;
        seen_meter = 1'b1;
        return;
      end
      CMD_RECALC_POWER: begin
        if (n == 0 || !seen_pwr) return;
        chg = recalc_power(n, it.tm);
      end
      CMD_APPLY_ENERGY: begin
        if (n == 0 || !seen_meter) return;
        app = apply_energy(n, it.tm);
        chg = app;
      end
      default: return;
    endcase
    for (int k = 0; k < n; k++) begin
      s.unit    = k[3:0];
      s.pwr     = u_pwr[k];
      s.nrg     = u_nrg[k];
      s.changed = chg;
      s.applied = app;
      s.last    = (k == n - 1);
      expect_q.push_back(s);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, time-zero values
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    item.valid = 1'b0;
    item.command = '0; item.unit_index = '0; item.capacity_request = '0;
    item.thermo_active = 1'b0; item.runtime_present = 1'b0; item.runtime_hours = '0;
    item.outdoor_power_w = '0; item.outdoor_energy_wh = '0; item.time_ms = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = CFG_ACTIVE_UNITS; cfg.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers from pend_q with random gaps between bursts
  // ---------------------------------------------------------------------------
  report_t cur;
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item.valid && item.ready) begin
        predict_shares(cur);
        n_accepted++;
      end
      if (!item.valid || item.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          item.command           <= cur.cmd;
          item.unit_index        <= cur.idx;
          item.capacity_request  <= cur.cap;
          item.thermo_active     <= cur.thermo;
          item.runtime_present   <= cur.rt_present;
          item.runtime_hours     <= cur.rt;
          item.outdoor_power_w   <= cur.pwr;
          item.outdoor_energy_wh <= cur.nrg;
          item.time_ms           <= cur.tm;
          item.valid             <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            // end of burst: some bursts are followed by no gap at all
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result sink with its own stall pattern, in-order compare
  // ---------------------------------------------------------------------------
  int     stall_mode = 0, stall_cnt = 0;
  share_t exp_s;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        n_results++;
        if (expect_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: unit %0d power %0d energy %0h",
                     res.result_unit, res.estimated_power_w, res.accumulated_energy);
        end else begin
          exp_s = expect_q.pop_front();
          if (res.result_unit !== exp_s.unit || res.estimated_power_w !== exp_s.pwr ||
              res.accumulated_energy !== exp_s.nrg || res.energy_changed !== exp_s.changed ||
              res.applied !== exp_s.applied || res.last_unit !== exp_s.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp u%0d p%0d e%0h c%0b a%0b l%0b / got u%0d p%0d e%0h c%0b a%0b l%0b",
                       exp_s.unit, exp_s.pwr, exp_s.nrg, exp_s.changed, exp_s.applied,
                       exp_s.last, res.result_unit, res.estimated_power_w,
                       res.accumulated_energy, res.energy_changed, res.applied,
                       res.last_unit);
          end
        end
      end
      // stall pattern is redrawn each time stall_cnt wraps; mode 0 never stalls
      stall_cnt++;
      if (stall_cnt >= 40) begin
        stall_cnt  = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= ($urandom_range(0, 3) != 0);
        2:       res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= stall_cnt[2];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [31:0] now_ms;
  int          meter_wh;

  task automatic push_item(input logic [2:0] c, input logic [3:0] ix, input logic [15:0] cp,
                           input logic th, input logic rp, input logic [23:0] rt,
                           input logic [20:0] pw, input logic [31:0] en,
                           input logic [31:0] tm);
    report_t it;
    it.cmd = c; it.idx = ix; it.cap = cp; it.thermo = th; it.rt_present = rp;
    it.rt = rt; it.pwr = pw; it.nrg = en; it.tm = tm;
    pend_q.push_back(it);
  endtask

  // let everything queued go through, then give the block time to settle
  task automatic drain();
    while (pend_q.size() > 0 || item.valid || expect_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e ix, input logic [31:0] d);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= ix;
    cfg.data  <= d;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (ix)
      CFG_ACTIVE_UNITS: m_active  = d[4:0];
      CFG_INVALID_CAP:  m_inv_cap = d[15:0];
      CFG_INVALID_RT:   m_inv_rt  = d[23:0];
      CFG_MIN_INTERVAL: m_min_iv  = d;
      CFG_MAX_INTERVAL: m_max_iv  = d;
      CFG_SEED_GRACE:   m_grace   = d;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] act, input logic [31:0] icap,
                           input logic [31:0] irt, input logic [31:0] mn,
                           input logic [31:0] mx, input logic [31:0] gr);
    write_reg(CFG_ACTIVE_UNITS, act);
    write_reg(CFG_INVALID_CAP, icap);
    write_reg(CFG_INVALID_RT, irt);
    write_reg(CFG_MIN_INTERVAL, mn);
    write_reg(CFG_MAX_INTERVAL, mx);
    write_reg(CFG_SEED_GRACE, gr);
  endtask

  function automatic logic [31:0] step_time();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1500);
      1, 2:    return $urandom_range(1000, 20000);
      3:       return $urandom_range(20000, 800000);
      4:       return $urandom;
      default: return m_grace + $urandom_range(0, 2);
    endcase
  endfunction

  task automatic push_unit_report(input int n);
    logic [3:0]  ix;
    logic [15:0] cp;
    logic [23:0] rt;
    ix = ($urandom_range(0, 7) != 0 && n > 0) ? $urandom_range(0, (n > 16 ? 16 : n) - 1)
                                              : $urandom_range(0, 15);
    case ($urandom_range(0, 7))
      0:       cp = 16'd0;
      1:       cp = 16'hFFFF;
      2:       cp = m_inv_cap + $urandom_range(0, 1) - 1;
      3:       cp = $urandom;
      default: cp = $urandom_range(1, 4000);
    endcase
    case ($urandom_range(0, 7))
      0:       rt = 24'd0;
      1:       rt = 24'hFFFFFF;
      2:       rt = $urandom;
      default: rt = $urandom_range(1, 60000);
    endcase
    push_item(CMD_UNIT_REPORT, ix, cp, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0,
              rt, $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(input int cnt, input bit with_meter);
    int r;
    logic [20:0] pw;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) push_unit_report(m_active);
      else if (r < 47) begin
        pw = ($urandom_range(0, 9) == 0) ? 21'($urandom) | 21'h100000 : $urandom_range(0, 1048575);
        push_item(CMD_OUTDOOR_POWER, $urandom, $urandom, $urandom, $urandom, $urandom,
                  pw, $urandom, $urandom);
      end else if (with_meter && r < 60) begin
        case ($urandom_range(0, 9))
          0:       meter_wh = meter_wh / 2;                     // meter reset
          1:       ;                                            // same reading
          2:       meter_wh = $urandom_range(0, 32'h7FFFFFFF);
          default: meter_wh = meter_wh + $urandom_range(1, 5000);
        endcase
        if (meter_wh < 0) meter_wh = 32'h7FFFFFFF;
        push_item(CMD_OUTDOOR_ENERGY, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, ($urandom_range(0, 19) == 0) ? 32'h80000000 | $urandom : meter_wh,
                  $urandom);
      end else if (r < 95) begin
        now_ms += step_time();
        push_item((with_meter && r >= 78) ? CMD_APPLY_ENERGY : CMD_RECALC_POWER, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, now_ms);
      end else begin
        push_item($urandom_range(CMD_BAD_LO, 7), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    m_active = 5'd1; m_inv_cap = 16'hFFFF; m_inv_rt = 24'hFFFFFF;
    m_min_iv = 32'd1000; m_max_iv = 32'd600000; m_grace = 32'd300000;
    for (int i = 0; i < MAX_UNITS; i++) begin
      u_cap[i] = '0; u_thermo[i] = 1'b0; u_rt_ok[i] = 1'b0; u_rt[i] = '0;
      u_pwr[i] = '0; u_anchor_pwr[i] = '0; u_nrg[i] = '0;
    end
    od_pwr = '0; od_nrg = '0; od_nrg_prev = '0; anchor_ms = '0; first_ms = '0;
    seen_pwr = 0; seen_meter = 0; anchor_ok = 0; first_ok = 0; seeded = 0; provisional = 0;
    n_accepted = 0; n_results = 0; n_errors = 0;
    meter_wh = 1000;
    @(posedge rst_ni);

    // directed, no meter yet: empty-state commands, bad codes, power integration
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 0);      // no power reading yet
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 0);      // no meter reading yet
    for (int c = CMD_BAD_LO; c <= 7; c++)
      push_item(c, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    push_item(CMD_UNIT_REPORT, 15, 16'hFFFF, 1, 1, 24'hFFFFFF, 0, 0, 0);
    push_item(CMD_UNIT_REPORT, 0, 0, 1, 0, 0, 0, 0, 0);
    push_item(CMD_OUTDOOR_POWER, 0, 0, 0, 0, 0, 21'h100000, 0, 0);  // most negative
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'd100);
    push_item(CMD_UNIT_REPORT, 0, 16'd1000, 1, 1, 24'd7, 0, 0, 0);
    push_item(CMD_OUTDOOR_POWER, 0, 0, 0, 0, 0, 21'h0FFFFF, 0, 0);
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'd600);      // below min interval
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'd700100);   // clamped interval
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFF00);
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'h00000500); // time wrapped
    drain();

    // integration phases (meter never seen yet)
    now_ms = 32'h1000;
    configure(4, 16'hFFFF, 24'hFFFFFF, 1000, 600000, 300000);
    random_phase(40, 0);
    drain();
    configure(16, 0, 0, 0, 32'hFFFFFFFF, 0);               // all weights zero: equal split
    random_phase(40, 0);
    drain();
    configure(31, 3000, 24'hFFFFFF, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
    random_phase(20, 0);
    drain();
    configure(0, 16'hFFFF, 24'hFFFFFF, 1000, 600000, 300000);  // no active units
    random_phase(12, 0);
    drain();

    // directed meter sequence: grace wait, provisional seed, spread, full seed, meter going back, unchanged reading
    configure(2, 16'hFFFF, 24'hFFFFFF, 1000, 600000, 300000);
    push_item(CMD_UNIT_REPORT, 0, 16'd500, 1, 1, 24'd30, 0, 0, 0);
    push_item(CMD_UNIT_REPORT, 1, 16'd1500, 1, 0, 24'd0, 0, 0, 0);
    push_item(CMD_OUTDOOR_ENERGY, 0, 0, 0, 0, 0, 0, 32'h80000000, 0);
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd5000);          // inside grace
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd305000);        // provisional seed
    push_item(CMD_OUTDOOR_ENERGY, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0);
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd306000);        // spread + drift
    push_item(CMD_UNIT_REPORT, 1, 16'd1500, 1, 1, 24'd90, 0, 0, 0);
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd307000);        // runtime seed
    push_item(CMD_RECALC_POWER, 0, 0, 0, 0, 0, 0, 0, 32'd308000);        // no integration
    push_item(CMD_OUTDOOR_ENERGY, 0, 0, 0, 0, 0, 0, 32'd1000, 0);
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd309000);        // meter went back
    push_item(CMD_APPLY_ENERGY, 0, 0, 0, 0, 0, 0, 0, 32'd310000);        // unchanged
    drain();

    // meter phases
    now_ms = 32'd400000;
    configure(5, 16'hFFFF, 24'hFFFFFF, 1000, 600000, 300000);
    random_phase(45, 1);
    drain();
    configure(16, 16'd2000, 24'd40000, 0, 32'hFFFFFFFF, 0);
    random_phase(45, 1);
    drain();
    configure(3, 0, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
    random_phase(40, 1);
    drain();
    configure(1, 16'd1, 24'd1, 500, 5000, 1000);
    random_phase(35, 1);
    drain();
    configure($urandom_range(1, 16), $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(40, 1);
    drain();
    configure(8, 16'hFFFF, 24'hFFFFFF, 1000, 600000, 300000);
    random_phase(40, 1);
    drain();

    $display("Covered %0d transfers in and %0d results out across 11 register settings,",
             n_accepted, n_results);
    $display("including power integration, meter seeding, spreading and empty states.");
    if (n_errors == 0 && expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, expect_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
